// ----- sv/tht_pkg.sv -----
package tht_pkg;

  localparam int MAX_SLOTS_DEF  = 1024;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [31:0] SEED1_INIT = 32'h0000_7FED;
  localparam logic [31:0] SEED2_INIT = 32'h0000_EEEE;

  // Seed table generator: seed = (seed * GEN_MUL + GEN_ADD) % GEN_MOD
  localparam logic [15:0] GEN_SEED0 = 16'd1;
  localparam logic [22:0] GEN_MUL   = 23'd125;
  localparam logic [22:0] GEN_ADD   = 23'd3;
  localparam logic [23:0] GEN_MOD   = 24'hAAAB;
  localparam int          TAB_DEPTH = 256;
  localparam int          NUM_HASH  = 3;

  localparam logic [10:0] ACTIVE_SLOTS_RST = 11'd1024;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] h0;
    logic [31:0] ha;
    logic [31:0] hb;
    logic [31:0] value;
  } job_t;

endpackage

// ----- sv/tht_front.sv -----
module tht_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_opcode,
  input  logic [7:0]     in_key_byte,
  input  logic           in_byte_valid,
  input  logic           in_key_last,
  input  logic [31:0]    in_value_in,
  input  logic           q_full,
  output logic           q_push,
  output tht_pkg::job_t  q_job
);

  typedef enum logic {GEN, RUN} fstate_t;

  fstate_t     state_r;
  logic [7:0]  gen_i_r;
  logic [2:0]  gen_k_r;
  logic        gen_half_r;
  logic        gen_ph_r;
  logic [22:0] gen_x_r;
  logic [15:0] seed_r;
  logic [11:0] hi_r;

  logic [11:0] tab_mem [tht_pkg::NUM_HASH][tht_pkg::TAB_DEPTH];
  logic [11:0] rd_r [tht_pkg::NUM_HASH];

  logic        s1_v_r;
  logic [7:0]  s1_ch_r;
  logic        s1_bv_r;
  logic        s1_last_r;
  logic [1:0]  s1_op_r;
  logic [31:0] s1_val_r;
  logic [31:0] s1_seed_r [tht_pkg::NUM_HASH];
  logic [31:0] s2_seed_r [tht_pkg::NUM_HASH];

  logic [31:0] s1_hash [tht_pkg::NUM_HASH];
  logic [31:0] s2_hash [tht_pkg::NUM_HASH];
  logic [31:0] h_out [tht_pkg::NUM_HASH];

  logic        adv;
  logic        accept;

  logic [24:0] x3;
  logic [7:0]  gq;
  logic [23:0] gprod;
  logic [23:0] gdiff;
  logic [15:0] seed_nxt;
  logic [11:0] entry;
  logic        ent_we;
  logic [8:0]  ent_j;

  // Reduction modulo 0xAAAB: 0xAAAB * 3 = 2^17 + 1, so (3x) >> 17 is the
  // quotient or one more, fixed by a single add.
  always_comb begin
    x3    = 25'(gen_x_r) * 25'd3;
    gq    = x3[24:17];
    gprod = 24'(gq) * tht_pkg::GEN_MOD;
    gdiff = 24'(gen_x_r) - gprod;
    if (gdiff[23]) begin
      seed_nxt = 16'(gdiff + tht_pkg::GEN_MOD);
    end else begin
      seed_nxt = gdiff[15:0];
    end
    entry  = hi_r + {4'd0, seed_nxt[7:0]};
    ent_we = 1'b0;
    ent_j  = {1'b0, gen_i_r};
    if (gen_k_r == 3'd0) begin
      ent_we = 1'b1;
    end else if (gen_k_r == 3'd1 && gen_i_r < 8'd32) begin
      ent_we = 1'b1;
      ent_j  = 9'd256 + {1'b0, gen_i_r};
    end
  end

  always_comb begin
    for (int t = 0; t < tht_pkg::NUM_HASH; t++) begin
      s1_hash[t] = 32'(rd_r[t]) ^ (s1_seed_r[t] + s2_seed_r[t]);
      s2_hash[t] = 32'(s1_ch_r) + s1_hash[t] + s2_seed_r[t] + {s2_seed_r[t][29:0], 2'b00}
                   + 32'd3;
      h_out[t]   = s1_bv_r ? s1_hash[t] : s1_seed_r[t];
    end
  end

  assign adv      = !(s1_v_r && s1_last_r && q_full);
  assign in_stall = (state_r != RUN) || !adv;
  assign accept   = in_valid && !in_stall;
  assign q_push   = s1_v_r && s1_last_r && !q_full;

  always_comb begin
    q_job.op    = s1_op_r;
    q_job.h0    = h_out[0];
    q_job.ha    = h_out[1];
    q_job.hb    = h_out[2];
    q_job.value = s1_val_r;
  end

  // Seed table generation sweep and its memories.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= GEN;
      gen_i_r    <= '0;
      gen_k_r    <= '0;
      gen_half_r <= 1'b0;
      gen_ph_r   <= 1'b0;
      seed_r     <= tht_pkg::GEN_SEED0;
    end else if (state_r == GEN) begin
      if (!gen_ph_r) begin
        gen_x_r  <= 23'(seed_r) * tht_pkg::GEN_MUL + tht_pkg::GEN_ADD;
        gen_ph_r <= 1'b1;
      end else begin
        seed_r     <= seed_nxt;
        gen_ph_r   <= 1'b0;
        gen_half_r <= !gen_half_r;
        if (!gen_half_r) begin
          hi_r <= {seed_nxt[7:0], 4'd0};
        end else begin
          if (gen_k_r == 3'd4) begin
            gen_k_r <= '0;
            gen_i_r <= gen_i_r + 8'd1;
            if (gen_i_r == 8'd255) begin
              state_r <= RUN;
            end
          end else begin
            gen_k_r <= gen_k_r + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == GEN && gen_ph_r && gen_half_r && ent_we) begin
      for (int t = 0; t < tht_pkg::NUM_HASH; t++) begin
        if (ent_j >= 9'(16 * t) && ent_j - 9'(16 * t) < 9'd256) begin
          tab_mem[t][8'(ent_j - 9'(16 * t))] <= entry;
        end
      end
    end
    if (accept) begin
      for (int t = 0; t < tht_pkg::NUM_HASH; t++) begin
        rd_r[t] <= tab_mem[t][in_key_byte];
      end
    end
  end

  // Hashing stage: one key byte per cycle while not stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      for (int t = 0; t < tht_pkg::NUM_HASH; t++) begin
        s1_seed_r[t] <= tht_pkg::SEED1_INIT;
        s2_seed_r[t] <= tht_pkg::SEED2_INIT;
      end
    end else if (adv) begin
      s1_v_r <= accept;
      if (accept) begin
        s1_ch_r   <= in_key_byte;
        s1_bv_r   <= in_byte_valid;
        s1_last_r <= in_key_last;
        s1_op_r   <= in_opcode;
        s1_val_r  <= in_value_in;
      end
      if (s1_v_r) begin
        for (int t = 0; t < tht_pkg::NUM_HASH; t++) begin
          if (s1_last_r) begin
            s1_seed_r[t] <= tht_pkg::SEED1_INIT;
            s2_seed_r[t] <= tht_pkg::SEED2_INIT;
          end else if (s1_bv_r) begin
            s1_seed_r[t] <= s1_hash[t];
            s2_seed_r[t] <= s2_hash[t];
          end
        end
      end
    end
  end

endmodule

// ----- sv/tht_queue.sv -----
module tht_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tht_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tht_pkg::job_t  head
);

  tht_pkg::job_t ent_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        ent_r[wr_ptr_r] <= push_job;
        wr_ptr_r        <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- sv/tht_back.sv -----
module tht_back #(
  parameter int MAX_SLOTS  = tht_pkg::MAX_SLOTS_DEF,
  parameter int VALUE_BITS = tht_pkg::VALUE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [10:0]    active_slots,
  input  logic           q_empty,
  input  tht_pkg::job_t  q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_status,
  output logic [31:0]    out_value_out,
  output logic [9:0]     out_slot_index
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int W  = 1 + 32 + 32 + VALUE_BITS;

  typedef enum logic [2:0] {CLEAR, IDLE, DIV, READ, CHECK, FINISH} bstate_t;

  bstate_t        state_r;
  tht_pkg::job_t  job_r;
  logic [CW-1:0]  n_r;
  logic [31:0]    div_r;
  logic [CW-1:0]  rem_r;
  logic [4:0]     cnt_r;
  logic [AW-1:0]  start_r;
  logic [AW-1:0]  pos_r;
  logic [AW-1:0]  clr_r;
  logic           found_r;
  logic           empty_r;
  logic [W-1:0]   rd_r;
  logic           out_valid_r;
  logic [1:0]     status_r;
  logic [31:0]    vout_r;
  logic [9:0]     sidx_r;

  logic [W-1:0]   mem [MAX_SLOTS];

  logic [31:0]    n_full;
  logic [CW:0]    trial;
  logic [CW-1:0]  rem_nxt;
  logic [CW-1:0]  pos_inc;
  logic [AW-1:0]  pos_nxt;
  logic           rd_used;
  logic [31:0]    rd_ca;
  logic [31:0]    rd_cb;
  logic [VALUE_BITS-1:0] rd_val;
  logic [VALUE_BITS-1:0] job_val;
  logic           out_free;
  logic           wr_en;
  logic [W-1:0]   wr_data;
  logic [1:0]     res_status;
  logic [31:0]    res_vout;
  logic [9:0]     res_sidx;

  always_comb begin
    n_full = (active_slots == 11'd0) ? 32'd1 : 32'(active_slots);
    if (n_full > 32'(MAX_SLOTS)) begin
      n_full = 32'(MAX_SLOTS);
    end
  end

  // Restoring remainder, one dividend bit per cycle.
  always_comb begin
    trial = {rem_r, div_r[31]};
    if (trial >= (CW + 1)'(n_r)) begin
      rem_nxt = CW'(trial - (CW + 1)'(n_r));
    end else begin
      rem_nxt = trial[CW-1:0];
    end
  end

  always_comb begin
    pos_inc = CW'(pos_r) + CW'(1);
    pos_nxt = (pos_inc == n_r) ? '0 : pos_inc[AW-1:0];
    rd_used = rd_r[W-1];
    rd_ca   = rd_r[W-2 -: 32];
    rd_cb   = rd_r[W-34 -: 32];
    rd_val  = rd_r[VALUE_BITS-1:0];
    job_val = VALUE_BITS'(64'(job_r.value));
  end

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == IDLE) && !q_empty;

  always_comb begin
    wr_en      = 1'b0;
    wr_data    = '0;
    res_status = tht_pkg::ST_NOT_FOUND;
    res_vout   = '0;
    res_sidx   = '0;
    unique case (job_r.op)
      tht_pkg::OP_ADD: begin
        if (found_r || empty_r) begin
          wr_en      = 1'b1;
          wr_data    = {1'b1, job_r.ha, job_r.hb, job_val};
          res_status = tht_pkg::ST_OK;
          res_sidx   = 10'(32'(pos_r));
        end else begin
          res_status = tht_pkg::ST_FULL;
        end
      end
      tht_pkg::OP_DELETE: begin
        if (found_r) begin
          wr_en      = 1'b1;
          wr_data    = {1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, {VALUE_BITS{1'b0}}};
          res_status = tht_pkg::ST_OK;
          res_sidx   = 10'(32'(pos_r));
        end
      end
      default: begin
        if (found_r) begin
          res_status = tht_pkg::ST_OK;
          res_vout   = 32'(64'(rd_val));
          res_sidx   = 10'(32'(pos_r));
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == CLEAR) begin
      mem[clr_r] <= '0;
    end else if (state_r == FINISH && out_free && wr_en) begin
      mem[pos_r] <= wr_data;
    end
    if (state_r == READ) begin
      rd_r <= mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (32'(clr_r) == 32'(MAX_SLOTS - 1)) begin
            state_r <= IDLE;
          end
        end
        IDLE: begin
          if (!q_empty) begin
            job_r   <= q_head;
            n_r     <= CW'(n_full);
            div_r   <= q_head.h0;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= DIV;
          end
        end
        DIV: begin
          rem_r <= rem_nxt;
          div_r <= {div_r[30:0], 1'b0};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            start_r <= rem_nxt[AW-1:0];
            pos_r   <= rem_nxt[AW-1:0];
            found_r <= 1'b0;
            empty_r <= 1'b0;
            state_r <= READ;
          end
        end
        READ: begin
          state_r <= CHECK;
        end
        CHECK: begin
          if (!rd_used) begin
            empty_r <= 1'b1;
            state_r <= FINISH;
          end else if (rd_ca == job_r.ha && rd_cb == job_r.hb) begin
            found_r <= 1'b1;
            state_r <= FINISH;
          end else if (pos_nxt == start_r) begin
            state_r <= FINISH;
          end else begin
            pos_r   <= pos_nxt;
            state_r <= READ;
          end
        end
        FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            status_r    <= res_status;
            vout_r      <= res_vout;
            sidx_r      <= res_sidx;
            state_r     <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_value_out  = vout_r;
  assign out_slot_index = sidx_r;

endmodule

// ----- sv/triple_hash_open_address_table.sv -----
// Key bytes are taken at one per cycle while in_stall is low; a byte without
// key_last gives no result. An item with key_last is hashed, queued, reduced
// modulo the slot count over the 32 bits of h0, then probes slots, with a READ
// and a CHECK state per probe, before out_valid rises. The back end takes a new
// key only in IDLE, once the last one is done. After reset the input stalls while
// the seed tables are generated; the slot memory is cleared within that time.
module triple_hash_open_address_table #(
  parameter int MAX_SLOTS  = tht_pkg::MAX_SLOTS_DEF,
  parameter int VALUE_BITS = tht_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_key_byte,
  input  logic        in_byte_valid,
  input  logic        in_key_last,
  input  logic [31:0] in_value_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_value_out,
  output logic [9:0]  out_slot_index
);

  logic [10:0]   active_slots_r;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  tht_pkg::job_t push_job;
  tht_pkg::job_t head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_slots_r <= tht_pkg::ACTIVE_SLOTS_RST;
    end else if (cfg_wr_en) begin
      active_slots_r <= cfg_wr_data;
    end
  end

  tht_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_key_byte   (in_key_byte),
    .in_byte_valid (in_byte_valid),
    .in_key_last   (in_key_last),
    .in_value_in   (in_value_in),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  tht_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_job)
  );

  tht_back #(
    .MAX_SLOTS  (MAX_SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .active_slots   (active_slots_r),
    .q_empty        (q_empty),
    .q_head         (head_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_value_out  (out_value_out),
    .out_slot_index (out_slot_index)
  );

endmodule

// ----- tb/sv/triple_hash_open_address_table_tb.sv -----
module triple_hash_open_address_table_tb;

  localparam int SLOTS = 1024;
  localparam int SEED_DEPTH = 1280;
  localparam int DRAIN_CYCLES = 2300;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  key_byte;
    logic        byte_valid;
    logic        key_last;
    logic [31:0] value;
  } key_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic [9:0]  slot;
  } lookup_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [7:0]  in_key_byte;
  logic        in_byte_valid;
  logic        in_key_last;
  logic [31:0] in_value_in;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [31:0] out_value_out;
  logic [9:0]  out_slot_index;

  triple_hash_open_address_table u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_key_byte    (in_key_byte),
    .in_byte_valid  (in_byte_valid),
    .in_key_last    (in_key_last),
    .in_value_in    (in_value_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_value_out  (out_value_out),
    .out_slot_index (out_slot_index)
  );

  key_item_t   pending_items[$];
  lookup_t     expected_lookups[$];
  int          errors = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // Shadow copy of the table.
  logic [11:0] seed_tab[SEED_DEPTH];
  logic [31:0] run_seed[6];
  logic [31:0] shadow_chk_a[SLOTS];
  logic [31:0] shadow_chk_b[SLOTS];
  logic        shadow_used[SLOTS];
  logic [31:0] shadow_value[SLOTS];
  logic [10:0] shadow_slots;

  function automatic void clear_seeds();
    for (int t = 0; t < 3; t++) begin
      run_seed[2*t]   = tht_pkg::SEED1_INIT;
      run_seed[2*t+1] = tht_pkg::SEED2_INIT;
    end
  endfunction

  function automatic void shadow_reset();
    int unsigned seed;
    int unsigned hi;
    int unsigned lo;
    seed = 1;
    for (int i = 0; i < 256; i++) begin
      for (int k = 0; k < 5; k++) begin
        seed = (seed * 125 + 3) % 32'hAAAB;
        hi = (seed & 8'hFF) << 4;
        seed = (seed * 125 + 3) % 32'hAAAB;
        lo = seed & 8'hFF;
        seed_tab[i + k*256] = 12'((hi + lo) & 12'hFFF);
      end
    end
    clear_seeds();
    for (int i = 0; i < SLOTS; i++) begin
      shadow_chk_a[i] = '1;
      shadow_chk_b[i] = '1;
      shadow_used[i]  = 1'b0;
      shadow_value[i] = '0;
    end
    shadow_slots = tht_pkg::ACTIVE_SLOTS_RST;
  endfunction

  // Hashes one accepted transfer; on key_last runs the probe and queues the lookup result.
  function automatic void apply_key_item(key_item_t it);
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] h0;
    logic [31:0] ha;
    logic [31:0] hb;
    int unsigned n;
    int unsigned start;
    int unsigned pos;
    bit found;
    bit empty;
    lookup_t res;
    found = 0;
    empty = 0;
    if (it.byte_valid) begin
      for (int t = 0; t < 3; t++) begin
        s1 = run_seed[2*t];
        s2 = run_seed[2*t+1];
        s1 = {20'd0, seed_tab[(t << 4) + it.key_byte]} ^ (s1 + s2);
        s2 = {24'd0, it.key_byte} + s1 + s2 + (s2 << 2) + 32'd3;
        run_seed[2*t]   = s1;
        run_seed[2*t+1] = s2;
      end
    end
    if (!it.key_last) return;
    h0 = run_seed[0];
    ha = run_seed[2];
    hb = run_seed[4];
    clear_seeds();
    n = shadow_slots;
    if (n == 0) n = 1;
    if (n > SLOTS) n = SLOTS;
    start = h0 % n;
    pos = start;
    forever begin
      if (!shadow_used[pos]) begin
        empty = 1;
        break;
      end
      if (shadow_chk_a[pos] == ha && shadow_chk_b[pos] == hb) begin
        found = 1;
        break;
      end
      pos = (pos + 1) % n;
      if (pos == start) break;
    end
    res.status = tht_pkg::ST_NOT_FOUND;
    res.value  = '0;
    res.slot   = '0;
    if (it.op == tht_pkg::OP_ADD) begin
      if (found || empty) begin
        shadow_chk_a[pos] = ha;
        shadow_chk_b[pos] = hb;
        shadow_used[pos]  = 1'b1;
        shadow_value[pos] = it.value;
        res.status = tht_pkg::ST_OK;
        res.slot   = 10'(pos);
      end else begin
        res.status = tht_pkg::ST_FULL;
      end
    end else if (it.op == tht_pkg::OP_DELETE) begin
      if (found) begin
        shadow_chk_a[pos] = '1;
        shadow_chk_b[pos] = '1;
        shadow_used[pos]  = 1'b0;
        shadow_value[pos] = '0;
        res.status = tht_pkg::ST_OK;
        res.slot   = 10'(pos);
      end
    end else if (found) begin
      res.status = tht_pkg::ST_OK;
      res.value  = shadow_value[pos];
      res.slot   = 10'(pos);
    end
    expected_lookups.push_back(res);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("triple_hash_open_address_table_tb: done, errors");
      $finish;
    end
  end

  // Driver: presents the head of the pending queue, holding it while stalled.
  always @(posedge clk) begin
    bit hold;
    hold = in_valid && in_stall;
    if (rst_n && in_valid && !in_stall) begin
      apply_key_item(pending_items[0]);
      void'(pending_items.pop_front());
    end
    if (!hold) begin
      if (rst_n && pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid      <= 1'b1;
        in_opcode     <= pending_items[0].op;
        in_key_byte   <= pending_items[0].key_byte;
        in_byte_valid <= pending_items[0].byte_valid;
        in_key_last   <= pending_items[0].key_last;
        in_value_in   <= pending_items[0].value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: every result transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    lookup_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_lookups.size() == 0) begin
        $error("unexpected result: status %0d value %h slot %0d",
               out_status, out_value_out, out_slot_index);
        errors++;
      end else begin
        exp_res = expected_lookups.pop_front();
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_status);
          errors++;
        end
        if (out_value_out !== exp_res.value) begin
          $error("value_out: expected %h, got %h", exp_res.value, out_value_out);
          errors++;
        end
        if (out_slot_index !== exp_res.slot) begin
          $error("slot_index: expected %0d, got %0d", exp_res.slot, out_slot_index);
          errors++;
        end
      end
    end
  end

  task automatic push_item(logic [1:0] op, logic [7:0] kb, logic bv, logic kl,
                           logic [31:0] val);
    key_item_t it;
    it.op = op;
    it.key_byte = kb;
    it.byte_valid = bv;
    it.key_last = kl;
    it.value = val;
    pending_items.push_back(it);
  endtask

  // Sends one key; the last byte rides on the key_last transfer or a dummy closes it.
  task automatic push_key(logic [1:0] op, byte unsigned key[$], logic [31:0] val,
                          bit with_noise);
    bit ride;
    int nb;
    nb = key.size();
    ride = (nb > 0) && $urandom_range(1);
    for (int i = 0; i < nb - (ride ? 1 : 0); i++) begin
      if (with_noise && $urandom_range(9) == 0)
        push_item(2'($urandom_range(3)), 8'($urandom), 1'b0, 1'b0, $urandom);
      push_item(2'($urandom_range(3)), key[i], 1'b1, 1'b0, $urandom);
    end
    if (ride)
      push_item(op, key[nb-1], 1'b1, 1'b1, val);
    else
      push_item(op, 8'($urandom), 1'b0, 1'b1, val);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_lookups.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_slots(logic [10:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_slots = v;
  endtask

  task automatic random_phase(int target);
    byte unsigned pool[12][$];
    byte unsigned key[$];
    int start_cnt;
    int r;
    logic [1:0] op;
    for (int k = 0; k < 12; k++) begin
      pool[k] = {};
      for (int b = 0; b < $urandom_range(4); b++) pool[k].push_back(8'($urandom));
    end
    start_cnt = pending_items.size();
    while (pending_items.size() - start_cnt < target) begin
      r = $urandom_range(99);
      if (r < 40) op = tht_pkg::OP_ADD;
      else if (r < 75) op = tht_pkg::OP_SEARCH;
      else if (r < 95) op = tht_pkg::OP_DELETE;
      else op = 2'd3;
      if ($urandom_range(19) == 0) begin
        key = {};
        for (int b = 0; b < $urandom_range(5); b++) key.push_back(8'($urandom));
      end else begin
        key = pool[$urandom_range(11)];
      end
      push_key(op, key, $urandom, 1'b1);
    end
  endtask

  initial begin
    byte unsigned kz[$];
    byte unsigned kff[$];
    byte unsigned kab[$];
    logic [10:0] slot_set[8];
    int send_set[8];
    int recv_set[8];
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_opcode = tht_pkg::OP_ADD;
    in_key_byte = '0;
    in_byte_valid = 1'b0;
    in_key_last = 1'b0;
    in_value_in = '0;
    out_stall = 1'b0;
    shadow_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    slot_set = '{11'd1024, 11'd7, 11'd2, 11'd0, 11'd16, 11'd2047, 11'd64, 11'd3};
    send_set = '{0, 79, 0, 8, 0, 79, 0, 8};
    recv_set = '{0, 0, 79, 8, 0, 0, 79, 8};

    // Directed: empty key, extreme bytes and values, overwrite, delete, odd opcode.
    kz  = {};
    kff = {8'hFF, 8'hFF, 8'hFF};
    kab = {8'h00, 8'hA5, 8'h5A, 8'hFF};
    push_key(tht_pkg::OP_SEARCH, kz, 32'h0, 0);
    push_key(tht_pkg::OP_ADD, kz, 32'hFFFF_FFFF, 0);
    push_key(tht_pkg::OP_SEARCH, kz, 32'h0, 0);
    push_key(tht_pkg::OP_ADD, kff, 32'h0, 0);
    push_key(tht_pkg::OP_ADD, kab, 32'h1234_5678, 0);
    push_key(tht_pkg::OP_SEARCH, kff, 32'hFFFF_FFFF, 0);
    push_key(tht_pkg::OP_ADD, kff, 32'hA5A5_5A5A, 0);
    push_key(tht_pkg::OP_SEARCH, kff, 32'h0, 0);
    push_key(2'd3, kab, 32'hFFFF_FFFF, 0);
    push_key(tht_pkg::OP_DELETE, kff, 32'h0, 0);
    push_key(tht_pkg::OP_SEARCH, kff, 32'h0, 0);
    push_key(tht_pkg::OP_DELETE, kff, 32'h0, 0);
    push_key(tht_pkg::OP_DELETE, kz, 32'h0, 0);
    push_key(tht_pkg::OP_SEARCH, kab, 32'h0, 0);
    push_item(2'd3, 8'h00, 1'b0, 1'b0, 32'h0);
    push_key(tht_pkg::OP_SEARCH, kz, 32'h0, 0);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      write_slots(slot_set[p]);
      send_idle_pct  = send_set[p];
      recv_stall_pct = recv_set[p];
      random_phase(130);
    end
    wait_drained();

    if (errors == 0 && expected_lookups.size() == 0)
      $display("triple_hash_open_address_table_tb: done, clean");
    else
      $display("triple_hash_open_address_table_tb: done, errors");
    $finish;
  end

endmodule
